// File: sv/fir_pkg.sv
package fir_pkg;

  localparam int PAGE_BYTES_DEF = 256;
  localparam int FRAME_BYTES    = 8;
  localparam int IDX_W          = 4;

  localparam logic [7:0]  HEADER_MARK      = 8'd16;
  localparam logic [7:0]  CHECK_XOR        = 8'hFF;
  localparam logic [31:0] FLASH_BASE_RESET = 32'h0800_8000;
  localparam logic [31:0] WORD_BYTES       = 32'd4;

  // page store: 256 bytes kept as four byte lanes of 64 rows
  localparam int STORE_DEPTH = 256;
  localparam int STORE_AW    = 8;
  localparam int LANES       = 4;
  localparam int LANE_W      = 2;
  localparam int ROWS        = STORE_DEPTH / LANES;
  localparam int ROW_W       = STORE_AW - LANE_W;

  localparam int              APB_AW          = 2;
  localparam logic [APB_AW-1:0] ADDR_FLASH_BASE = 2'd0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BYTE,
    S_END,
    S_EMIT_RD,
    S_EMIT_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                we;
    logic [STORE_AW-1:0] waddr;
    logic [7:0]          wdata;
    logic                re;
    logic [ROW_W-1:0]    rrow;
  } pbuf_req_t;

  // end-around byte sum: past 255 take off 255
  function automatic logic [7:0] csum_add(logic [7:0] s, logic [7:0] b);
    logic [8:0] t;
    t = {1'b0, s} + {1'b0, b};
    return t[8] ? (t[7:0] + 8'd1) : t[7:0];
  endfunction

endpackage

// File: sv/fir_if.sv
interface fir_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_0;
  logic [7:0] byte_1;
  logic [7:0] byte_2;
  logic [7:0] byte_3;
  logic [7:0] byte_4;
  logic [7:0] byte_5;
  logic [7:0] byte_6;
  logic [7:0] byte_7;

  modport source (
    output valid, byte_0, byte_1, byte_2, byte_3, byte_4, byte_5, byte_6, byte_7,
    input  ready
  );
  modport sink (
    input  valid, byte_0, byte_1, byte_2, byte_3, byte_4, byte_5, byte_6, byte_7,
    output ready
  );
endinterface

interface fir_result_if;
  logic        valid;
  logic        ready;
  logic        write_valid;
  logic [31:0] flash_address;
  logic [31:0] flash_word;
  logic        acknowledge;
  logic        finished;
  logic        image_ok;
  logic        last;

  modport source (
    output valid, write_valid, flash_address, flash_word, acknowledge, finished,
           image_ok, last,
    input  ready
  );
  modport sink (
    input  valid, write_valid, flash_address, flash_word, acknowledge, finished,
           image_ok, last,
    output ready
  );
endinterface

// File: sv/fir_ram.sv
module fir_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/fir_page_buf.sv
module fir_page_buf (
  input  logic              clk,
  input  logic              rst,
  input  fir_pkg::pbuf_req_t req,
  output logic [31:0]       word
);

  logic [fir_pkg::STORE_DEPTH-1:0] valid;
  logic [fir_pkg::LANES-1:0]       lane_vld;

  // bytes never written since reset read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.we) begin
      valid[req.waddr] <= 1'b1;
    end
  end

  genvar k;
  for (k = 0; k < fir_pkg::LANES; k++) begin : g_lane
    logic       lane_we;
    logic [7:0] lane_rdata;

    assign lane_we = req.we && (req.waddr[fir_pkg::LANE_W-1:0] == fir_pkg::LANE_W'(k));

    fir_ram #(
      .WIDTH(8),
      .DEPTH(fir_pkg::ROWS)
    ) u_ram (
      .clk  (clk),
      .we   (lane_we),
      .waddr(req.waddr[fir_pkg::STORE_AW-1:fir_pkg::LANE_W]),
      .wdata(req.wdata),
      .re   (req.re),
      .raddr(req.rrow),
      .rdata(lane_rdata)
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        lane_vld[k] <= 1'b0;
      end else if (req.re) begin
        lane_vld[k] <= valid[{req.rrow, fir_pkg::LANE_W'(k)}];
      end
    end

    assign word[8*k +: 8] = lane_vld[k] ? lane_rdata : 8'd0;
  end

endmodule

// File: sv/firmware_image_receiver_top.sv
// Channel   Dir  Handshake     Word
// frame     in   valid/ready   byte_0 .. byte_7 (one 8-byte frame)
// result    out  valid/ready   write_valid, flash_address, flash_word, acknowledge,
//                              finished, image_ok, last
// apb       in   psel/penable  flash_base at offset 0
//
// A data frame runs: accept, 8 byte steps through one byte-wide sum/store unit, an end
// step and a result. Word writes replace the empty result: a full page, or the tail at
// the end of the image, goes out one flash word a cycle from the 4-lane page store while
// the result slot is free. A header is answered via S_DONE; frames are taken in idle only.
// Reset is synchronous; page store bytes have valid bits, so no clearing pass.
// A stalled result holds in the output register and the sequencer waits on it.
module firmware_image_receiver_top #(
  parameter int PAGE_BYTES = fir_pkg::PAGE_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  fir_frame_if.sink                  frame,
  fir_result_if.source               result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fir_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int FILL_W = $clog2(PAGE_BYTES);
  localparam int NWORDS = (PAGE_BYTES + 3) / 4;

  fir_pkg::state_t state, state_next;

  logic [31:0]                  flash_base;
  logic [8*fir_pkg::FRAME_BYTES-1:0] frame_q;
  logic [fir_pkg::IDX_W-1:0]    idx;
  logic                         transfer_open;
  logic [31:0]                  remaining;
  logic [FILL_W-1:0]            fill;
  logic [7:0]                   sum;
  logic [7:0]                   expected;
  logic [31:0]                  write_pointer;
  logic [31:0]                  word_addr;
  logic [fir_pkg::ROW_W-1:0]    words_left;
  logic [fir_pkg::ROW_W-1:0]    rd_row;
  logic                         emit_page;
  logic                         emit_last;
  logic                         emit_fin;
  logic                         wrote_any;
  logic                         fin_flag;

  logic                         out_valid;
  logic                         out_write_valid;
  logic [31:0]                  out_addr;
  logic [31:0]                  out_word;
  logic                         out_last;
  logic                         out_fin;
  logic                         out_ok;

  logic                         frame_fire;
  logic                         is_header;
  logic                         slot_free;
  logic                         byte_store;
  logic                         page_full;
  logic                         rd_en;
  logic                         load_word;
  logic                         load_empty;
  logic                         check_ok;
  logic [31:0]                  rem_dec;
  logic [2:0]                   bytes_after;
  logic                         tail_follows;
  logic [31:0]                  size_in;
  logic [31:0]                  pbuf_word;
  fir_pkg::pbuf_req_t           pbuf_req;

  assign frame_fire = frame.valid && frame.ready;
  assign is_header  = (frame.byte_0 == fir_pkg::HEADER_MARK);
  assign slot_free  = !out_valid || result.ready;
  assign check_ok   = ((sum ^ fir_pkg::CHECK_XOR) == expected);
  assign rem_dec    = remaining - 32'd1;
  assign bytes_after = 3'd7 - idx[2:0];
  // a flush mid-frame is not the last result when the rest of the frame ends the image
  assign tail_follows = (rem_dec != 32'd0) && (rem_dec[31:3] == '0) &&
                        (rem_dec[2:0] <= bytes_after);
  assign size_in = {frame.byte_4, frame.byte_3, frame.byte_2, frame.byte_1};

  // ---------------- sequencer ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      fir_pkg::S_IDLE: begin
        if (frame_fire) begin
          if (transfer_open) begin
            state_next = fir_pkg::S_BYTE;
          end else if (is_header) begin
            state_next = fir_pkg::S_DONE;
          end
        end
      end
      fir_pkg::S_BYTE: begin
        if (page_full) begin
          state_next = fir_pkg::S_EMIT_RD;
        end else if (idx == fir_pkg::IDX_W'(fir_pkg::FRAME_BYTES - 1)) begin
          state_next = fir_pkg::S_END;
        end
      end
      fir_pkg::S_END: begin
        if (remaining == 32'd0 && fill != '0) begin
          state_next = fir_pkg::S_EMIT_RD;
        end else if (wrote_any) begin
          state_next = fir_pkg::S_IDLE;
        end else begin
          state_next = fir_pkg::S_DONE;
        end
      end
      fir_pkg::S_EMIT_RD: begin
        state_next = fir_pkg::S_EMIT_WR;
      end
      fir_pkg::S_EMIT_WR: begin
        if (slot_free && words_left == '0) begin
          if (!emit_page) begin
            state_next = fir_pkg::S_IDLE;
          end else if (idx == fir_pkg::IDX_W'(fir_pkg::FRAME_BYTES)) begin
            state_next = fir_pkg::S_END;
          end else begin
            state_next = fir_pkg::S_BYTE;
          end
        end
      end
      fir_pkg::S_DONE: begin
        if (slot_free) begin
          state_next = fir_pkg::S_IDLE;
        end
      end
      default: state_next = fir_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    frame.ready = 1'b0;
    byte_store  = 1'b0;
    page_full   = 1'b0;
    rd_en       = 1'b0;
    load_word   = 1'b0;
    load_empty  = 1'b0;
    unique case (state)
      fir_pkg::S_IDLE: frame.ready = 1'b1;
      fir_pkg::S_BYTE: begin
        byte_store = (remaining != 32'd0);
        page_full  = byte_store && (fill == FILL_W'(PAGE_BYTES - 1));
      end
      fir_pkg::S_END:     ;
      fir_pkg::S_EMIT_RD: rd_en = 1'b1;
      fir_pkg::S_EMIT_WR: begin
        load_word = slot_free;
        rd_en     = slot_free && (words_left != '0);
      end
      fir_pkg::S_DONE: load_empty = slot_free;
      default: ;
    endcase
  end

  // ---------------- control state ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= fir_pkg::S_IDLE;
      flash_base    <= fir_pkg::FLASH_BASE_RESET;
      idx           <= '0;
      transfer_open <= 1'b0;
      remaining     <= '0;
      fill          <= '0;
      sum           <= '0;
      expected      <= '0;
      write_pointer <= fir_pkg::FLASH_BASE_RESET;
      words_left    <= '0;
      rd_row        <= '0;
      emit_page     <= 1'b0;
      emit_last     <= 1'b0;
      emit_fin      <= 1'b0;
      wrote_any     <= 1'b0;
      fin_flag      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;

      if (psel && penable && pwrite && pready && paddr == fir_pkg::ADDR_FLASH_BASE) begin
        flash_base <= pwdata;
      end

      if (frame_fire) begin
        idx       <= '0;
        wrote_any <= 1'b0;
        fin_flag  <= 1'b0;
        if (!transfer_open && is_header) begin
          write_pointer <= flash_base;
          remaining     <= size_in;
          expected      <= frame.byte_5;
          fill          <= '0;
          sum           <= '0;
          transfer_open <= 1'b1;
        end
      end

      if (state == fir_pkg::S_BYTE) begin
        idx <= idx + fir_pkg::IDX_W'(1);
      end

      if (byte_store) begin
        remaining <= rem_dec;
        sum       <= fir_pkg::csum_add(sum, frame_q[7:0]);
        if (!page_full) begin
          fill <= fill + FILL_W'(1);
        end
      end

      if (page_full) begin
        words_left <= fir_pkg::ROW_W'(NWORDS - 1);
        rd_row     <= '0;
        emit_page  <= 1'b1;
        emit_last  <= !tail_follows;
        emit_fin   <= (rem_dec == 32'd0);
        wrote_any  <= 1'b1;
      end

      if (state == fir_pkg::S_END && remaining == 32'd0) begin
        transfer_open <= 1'b0;
        fin_flag      <= 1'b1;
        if (fill != '0) begin
          words_left <= fir_pkg::ROW_W'((fir_pkg::STORE_AW'(fill) -
                                         fir_pkg::STORE_AW'(1)) >> 2);
          rd_row     <= '0;
          emit_page  <= 1'b0;
          emit_last  <= 1'b1;
          emit_fin   <= 1'b1;
          wrote_any  <= 1'b1;
        end
      end

      if (rd_en) begin
        rd_row <= rd_row + fir_pkg::ROW_W'(1);
      end

      if (load_word) begin
        if (words_left != '0) begin
          words_left <= words_left - fir_pkg::ROW_W'(1);
        end else if (emit_page) begin
          write_pointer <= write_pointer + 32'(PAGE_BYTES);
          fill          <= '0;
        end
      end

      if (load_word || load_empty) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---------------- payload ----------------
  always_ff @(posedge clk) begin
    if (frame_fire) begin
      frame_q <= {frame.byte_7, frame.byte_6, frame.byte_5, frame.byte_4,
                  frame.byte_3, frame.byte_2, frame.byte_1, frame.byte_0};
    end else if (state == fir_pkg::S_BYTE) begin
      frame_q <= frame_q >> 8;
    end

    if (page_full || (state == fir_pkg::S_END && remaining == 32'd0)) begin
      word_addr <= write_pointer;
    end else if (load_word) begin
      word_addr <= word_addr + fir_pkg::WORD_BYTES;
    end

    if (load_word) begin
      out_write_valid <= 1'b1;
      out_addr        <= word_addr;
      out_word        <= pbuf_word;
      out_last        <= emit_last && (words_left == '0);
      out_fin         <= emit_last && emit_fin && (words_left == '0);
      out_ok          <= emit_last && emit_fin && (words_left == '0) && check_ok;
    end else if (load_empty) begin
      out_write_valid <= 1'b0;
      out_addr        <= '0;
      out_word        <= '0;
      out_last        <= 1'b1;
      out_fin         <= fin_flag;
      out_ok          <= fin_flag && check_ok;
    end
  end

  assign pbuf_req.we    = byte_store;
  assign pbuf_req.waddr = fir_pkg::STORE_AW'(fill);
  assign pbuf_req.wdata = frame_q[7:0];
  assign pbuf_req.re    = rd_en;
  assign pbuf_req.rrow  = rd_row;

  fir_page_buf u_page_buf (
    .clk (clk),
    .rst (rst),
    .req (pbuf_req),
    .word(pbuf_word)
  );

  assign result.valid         = out_valid;
  assign result.write_valid   = out_write_valid;
  assign result.flash_address = out_addr;
  assign result.flash_word    = out_word;
  assign result.acknowledge   = out_last;
  assign result.finished      = out_fin;
  assign result.image_ok      = out_ok;
  assign result.last          = out_last;

  assign pready = 1'b1;
  assign prdata = (paddr == fir_pkg::ADDR_FLASH_BASE) ? flash_base : 32'd0;

  // ---------------- assertions ----------------
  a_idle_drop: assert property (@(posedge clk) disable iff (rst)
    (frame_fire && !transfer_open && !is_header) |=> (state == fir_pkg::S_IDLE))
    else $error("ignored frame left idle");

  a_header: assert property (@(posedge clk) disable iff (rst)
    (frame_fire && !transfer_open && is_header) |=>
      (transfer_open && state == fir_pkg::S_DONE && remaining == $past(size_in)))
    else $error("header did not open transfer");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    (int'(fill) < PAGE_BYTES))
    else $error("fill index past page");

  a_byte_open: assert property (@(posedge clk) disable iff (rst)
    (state == fir_pkg::S_BYTE) |-> transfer_open)
    else $error("byte step with no open transfer");

  a_fin_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_fin) |-> out_last)
    else $error("finished word not marked last");

endmodule
